// File: rtl/env_sample_outlier_validator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the environmental sample outlier validator
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ENV_SAMPLE_OUTLIER_VALIDATOR_MACROS_SVH
`define ENV_SAMPLE_OUTLIER_VALIDATOR_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ESOV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esov assertion failed");
// next-cycle implication
`define ESOV_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esov assertion failed");
`else
`define ESOV_ASSERT_IMP(label, ante, cons)
`define ESOV_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: rtl/esov_pkg.sv
// ---------------------------------------------------------------------------
// esov_pkg
// Field widths, reject codes, register indexes and the controller/datapath
// command and status bundles.
// ---------------------------------------------------------------------------
package esov_pkg;

    localparam int TEMP_W      = 15;
    localparam int HUM_W       = 14;
    localparam int PRES_W      = 17;
    localparam int LIM_W       = 14;
    localparam int RSN_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    typedef logic [RSN_W-1:0] reason_t;

    localparam reason_t RSN_OK    = 3'd0;
    localparam reason_t RSN_MISS  = 3'd1;
    localparam reason_t RSN_TEMP  = 3'd2;
    localparam reason_t RSN_HUM   = 3'd3;
    localparam reason_t RSN_PRES  = 3'd4;
    localparam reason_t RSN_HJUMP = 3'd5;
    localparam reason_t RSN_PJUMP = 3'd6;
    localparam reason_t RSN_DEV   = 3'd7;

    // humidity ceiling, 100.00 %
    localparam logic [HUM_W-1:0] HUM_MAX = 14'd10000;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HJ_LIM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PJ_LIM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_LIM  = 3'd6;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN_RST = -15'sd1000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_RST = 15'sd4000;
    localparam logic [PRES_W-1:0]        PRES_MIN_RST = 17'd85000;
    localparam logic [PRES_W-1:0]        PRES_MAX_RST = 17'd110000;
    localparam logic [LIM_W-1:0]         HJ_LIM_RST   = 14'd2000;
    localparam logic [LIM_W-1:0]         PJ_LIM_RST   = 14'd150;
    localparam logic [LIM_W-1:0]         DEV_LIM_RST  = 14'd150;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_min;
        logic signed [TEMP_W-1:0] temp_max;
        logic [PRES_W-1:0]        pres_min;
        logic [PRES_W-1:0]        pres_max;
        logic [LIM_W-1:0]         hj_lim;
        logic [LIM_W-1:0]         pj_lim;
        logic [LIM_W-1:0]         dev_lim;
    } cfg_t;

    typedef struct packed {
        logic load;      // capture the input beat
        logic check;     // run range and jump checks
        logic sum_step;  // one history read / accumulate
        logic mul;       // form p*count and limit*count
        logic dev;       // deviation compare, divider init
        logic div_step;  // one quotient bit
        logic out_load;  // load result, commit pressure
    } cmd_t;

    typedef struct packed {
        logic skip_dev;
        logic sum_done;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/esov_ctrl.sv
// ---------------------------------------------------------------------------
// esov_ctrl
// Sequencer: one sample at a time through check, sum, multiply, deviation,
// divide and output; a sample that needs no deviation check skips to output.
// ---------------------------------------------------------------------------
module esov_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  esov_pkg::stat_t stat,
    output esov_pkg::cmd_t  cmd
);
    import esov_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DEV   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.skip_dev ? S_OUT : S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (stat.sum_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DEV;
            end
            S_DEV:
            begin
                cmd.dev    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.out_load = stat.out_free;
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/esov_dp.sv
// ---------------------------------------------------------------------------
// esov_dp
// Datapath: sample registers, checks, humidity/pressure state, history
// memory, accumulator, multipliers, bit-serial divider and output register.
// ---------------------------------------------------------------------------
module esov_dp #(
    parameter int HISTORY_DEPTH = 5
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  esov_pkg::cfg_t                     cfg,
    input  esov_pkg::cmd_t                     cmd,
    output esov_pkg::stat_t                    stat,
    input  logic                               in_missing,
    input  logic [esov_pkg::IN_TDATA_W-1:0]    in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [esov_pkg::OUT_TDATA_W-1:0]   out_data
);
    import esov_pkg::*;

    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = PRES_W + CNT_W;
    localparam int LC_W   = LIM_W + CNT_W;
    localparam int DIVC_W = $clog2(PRES_W);

    // sample
    logic                     miss_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [HUM_W-1:0]         hum_reg;
    logic [PRES_W-1:0]        pres_reg;

    // history state
    logic [HUM_W-1:0]  last_hum_reg;
    logic              hum_seen_reg;
    logic [PRES_W-1:0] last_pres_reg;
    logic              pres_seen_reg;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic              full_reg;
    logic [PRES_W-1:0] hist_mem [HISTORY_DEPTH];

    // per-sample work
    reason_t           reason_reg;
    logic              dev_need_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  sum_idx_reg;
    logic              rd_vld_reg;
    logic [PRES_W-1:0] rd_data_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  pc_reg;
    logic [LC_W-1:0]   lc_reg;
    logic              dev_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  dvs_reg;
    logic [PRES_W-1:0] quo_reg;
    logic [DIVC_W-1:0] div_cnt_reg;

    // result
    logic              out_valid_reg;
    logic              acc_reg;
    reason_t           rsn_out_reg;
    logic [PRES_W-1:0] avg_reg;

    logic [HUM_W-1:0]  h_diff;
    logic [PRES_W-1:0] p_diff;
    logic [CNT_W-1:0]  count_c;
    reason_t           reason_c;
    logic              dev_need_c;
    logic              hum_commit;
    logic [SUM_W-1:0]  dev_diff;
    logic              rem_ge;
    reason_t           final_rsn;
    logic              pres_commit;
    logic [IDX_W-1:0]  wr_idx_inc;

    always_comb
    begin
        h_diff  = (hum_reg > last_hum_reg) ? hum_reg - last_hum_reg : last_hum_reg - hum_reg;
        p_diff  = (pres_reg > last_pres_reg) ? pres_reg - last_pres_reg
                                             : last_pres_reg - pres_reg;
        count_c = full_reg ? CNT_W'(HISTORY_DEPTH) : CNT_W'(wr_idx_reg);

        // first failing check wins
        if (miss_reg)
            reason_c = RSN_MISS;
        else if ($signed(temp_reg) < $signed(cfg.temp_min)
                 || $signed(temp_reg) > $signed(cfg.temp_max))
            reason_c = RSN_TEMP;
        else if (hum_reg > HUM_MAX)
            reason_c = RSN_HUM;
        else if (pres_reg < cfg.pres_min || pres_reg > cfg.pres_max)
            reason_c = RSN_PRES;
        else if (hum_seen_reg && h_diff > cfg.hj_lim)
            reason_c = RSN_HJUMP;
        else if (pres_seen_reg && p_diff > {{(PRES_W-LIM_W){1'b0}}, cfg.pj_lim})
            reason_c = RSN_PJUMP;
        else
            reason_c = RSN_OK;

        hum_commit = (reason_c == RSN_OK) || (reason_c == RSN_PJUMP);
        dev_need_c = (reason_c == RSN_OK) && pres_seen_reg && (count_c != '0);

        dev_diff = (pc_reg > sum_reg) ? pc_reg - sum_reg : sum_reg - pc_reg;
        rem_ge   = (rem_reg >= dvs_reg);

        final_rsn   = (dev_need_reg && dev_reg) ? RSN_DEV : reason_reg;
        pres_commit = cmd.out_load && (final_rsn == RSN_OK);
        wr_idx_inc  = (wr_idx_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    end

    assign stat.skip_dev = !dev_need_c;
    assign stat.sum_done = (sum_idx_reg == count_reg) && !rd_vld_reg;
    assign stat.div_done = (div_cnt_reg == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    // control and committed state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_hum_reg  <= '0;
            hum_seen_reg  <= 1'b0;
            last_pres_reg <= '0;
            pres_seen_reg <= 1'b0;
            wr_idx_reg    <= '0;
            full_reg      <= 1'b0;
            sum_idx_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.check && hum_commit)
            begin
                last_hum_reg <= hum_reg;
                hum_seen_reg <= 1'b1;
            end
            if (cmd.check)
            begin
                sum_idx_reg <= '0;
                rd_vld_reg  <= 1'b0;
            end
            else if (cmd.sum_step)
            begin
                rd_vld_reg <= (sum_idx_reg != count_reg);
                if (sum_idx_reg != count_reg)
                    sum_idx_reg <= sum_idx_reg + 1'b1;
            end
            if (pres_commit)
            begin
                last_pres_reg <= pres_reg;
                pres_seen_reg <= 1'b1;
                wr_idx_reg    <= wr_idx_inc;
                if (wr_idx_inc == '0)
                    full_reg <= 1'b1;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (pres_commit)
            hist_mem[wr_idx_reg] <= pres_reg;
        if (cmd.sum_step && sum_idx_reg != count_reg)
            rd_data_reg <= hist_mem[sum_idx_reg[IDX_W-1:0]];
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            miss_reg <= in_missing;
            temp_reg <= in_data[TEMP_W-1:0];
            hum_reg  <= in_data[TEMP_W+HUM_W-1:TEMP_W];
            pres_reg <= in_data[TEMP_W+HUM_W+PRES_W-1:TEMP_W+HUM_W];
        end
        if (cmd.check)
        begin
            reason_reg   <= reason_c;
            dev_need_reg <= dev_need_c;
            count_reg    <= count_c;
            sum_reg      <= '0;
        end
        else if (cmd.sum_step && rd_vld_reg)
        begin
            sum_reg <= sum_reg + {{CNT_W{1'b0}}, rd_data_reg};
        end
        if (cmd.mul)
        begin
            pc_reg <= {{CNT_W{1'b0}}, pres_reg} * {{PRES_W{1'b0}}, count_reg};
            lc_reg <= {{CNT_W{1'b0}}, cfg.dev_lim} * {{LIM_W{1'b0}}, count_reg};
        end
        if (cmd.dev)
        begin
            dev_reg     <= dev_diff > {{(SUM_W-LC_W){1'b0}}, lc_reg};
            rem_reg     <= sum_reg;
            dvs_reg     <= {1'b0, count_reg, {(PRES_W-1){1'b0}}};
            quo_reg     <= '0;
            div_cnt_reg <= DIVC_W'(PRES_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
                rem_reg <= rem_reg - dvs_reg;
            quo_reg     <= {quo_reg[PRES_W-2:0], rem_ge};
            dvs_reg     <= dvs_reg >> 1;
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
        if (cmd.out_load)
        begin
            acc_reg     <= (final_rsn == RSN_OK);
            rsn_out_reg <= final_rsn;
            avg_reg     <= dev_need_reg ? quo_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_TDATA_W-1-RSN_W-PRES_W){1'b0}}, avg_reg, rsn_out_reg, acc_reg};

endmodule

// File: rtl/env_sample_outlier_validator.sv
// ---------------------------------------------------------------------------
// env_sample_outlier_validator
// Accepts or rejects one temperature/humidity/pressure sample with a reason.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake           Content
// s_*       in   s_tvalid/s_tready   one sample, tuser = missing flag
// m_*       out  m_tvalid/m_tready   verdict, reason code, pressure average
// cfg_*     in   cfg_valid/cfg_ready register index and write data
//
// A sample that never reaches the deviation check (an early reject or the
// first pressure) goes from check straight to output. With the deviation
// check the history is summed one memory read per cycle and the average
// comes from a 17-step restoring divider.
// Reset (rst_n low, asynchronous) clears the history state and loads the
// register defaults. A stalled m_tready holds the result in the output
// register; the next sample is still taken and waits only at its own output.
// ---------------------------------------------------------------------------
`include "env_sample_outlier_validator_macros.svh"

module env_sample_outlier_validator #(
    parameter int HISTORY_DEPTH = 5
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // sample in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [14:0] temperature_centi, [28:15] humidity_centi, [45:29] pressure_pa
    input  logic [esov_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [0] sample_missing
    input  logic                                s_tuser,
    // verdict out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] accepted, [3:1] reject_reason, [20:4] pressure_average
    output logic [esov_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [esov_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [esov_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import esov_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    // result fields, named for the checks below
    reason_t           out_rsn;
    logic [PRES_W-1:0] out_avg;

    assign out_rsn = m_tdata[3:1];
    assign out_avg = m_tdata[20:4];

    // each write is registered directly; never stall the port
    assign cfg_ready = 1'b1;

    // Decode the register index; unknown indexes drop the beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_min <= TEMP_MIN_RST;
            cfg_reg.temp_max <= TEMP_MAX_RST;
            cfg_reg.pres_min <= PRES_MIN_RST;
            cfg_reg.pres_max <= PRES_MAX_RST;
            cfg_reg.hj_lim   <= HJ_LIM_RST;
            cfg_reg.pj_lim   <= PJ_LIM_RST;
            cfg_reg.dev_lim  <= DEV_LIM_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEMP_MIN: cfg_reg.temp_min <= cfg_data[TEMP_W-1:0];
                REG_TEMP_MAX: cfg_reg.temp_max <= cfg_data[TEMP_W-1:0];
                REG_PRES_MIN: cfg_reg.pres_min <= cfg_data[PRES_W-1:0];
                REG_PRES_MAX: cfg_reg.pres_max <= cfg_data[PRES_W-1:0];
                REG_HJ_LIM:   cfg_reg.hj_lim   <= cfg_data[LIM_W-1:0];
                REG_PJ_LIM:   cfg_reg.pj_lim   <= cfg_data[LIM_W-1:0];
                REG_DEV_LIM:  cfg_reg.dev_lim  <= cfg_data[LIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: check, sum, multiply, deviation, divide and output.
    esov_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: checks, history, arithmetic and the output register.
    esov_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .stat       (stat),
        .in_missing (s_tuser),
        .in_data    (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

    // one sample in flight: the input closes right after a beat is taken
    `ESOV_ASSERT_NXT(a_single_item, s_tvalid && s_tready, !s_tready)
    // a loaded result is presented on the next cycle
    `ESOV_ASSERT_NXT(a_out_load_valid, cmd.out_load, m_tvalid)
    // the accepted flag agrees with the reason code
    `ESOV_ASSERT_IMP(a_accept_flag, m_tvalid, m_tdata[0] == (m_tdata[3:1] == RSN_OK))
    // an average shows only when the deviation check ran
    `ESOV_ASSERT_IMP(a_avg_with_dev, m_tvalid && |out_avg, out_rsn == RSN_OK || out_rsn == RSN_DEV)

endmodule
